/* hw/rtl/hrsf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsf_pkg: shared types and constants
// Field layouts, register map, phase codes and timing constants of the
// hopping receiver synchronizer.
// ----------------------------------------------------------------------------
package hrsf_pkg;

  localparam int HOP_CHANNELS_DEF     = 47;
  localparam int MAX_PACKET_BYTES_DEF = 32;

  localparam int HOP_W = 6;

  localparam logic [7:0]  PKT_LEN_BYTE   = 8'h11;
  localparam logic [7:0]  MIN_RX_BYTES   = 8'd7;
  localparam logic [31:0] LATE_MS        = 32'd2;
  localparam logic [31:0] LOST_MS        = 32'd1000;
  localparam logic [31:0] SEARCH_HOP_MS  = 32'd45;
  localparam logic [31:0] SLOT_MS        = 32'd9;
  localparam logic [31:0] TX_SLOT_MS     = 32'd18;
  localparam logic [31:0] TX_DELAY_MS    = 32'd2;
  localparam logic [31:0] TX_LEN_MS      = 32'd8;
  localparam logic [31:0] BUTTON_HOLD_MS = 32'd2000;
  localparam logic [15:0] FS_DELAY_RST   = 16'd1000;
  localparam logic [1:0]  TX_SLOT        = 2'd3;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_BOUND     = 3'd0,
    REG_BIND_CODE = 3'd1,
    REG_FS_DELAY  = 3'd2,
    REG_FS_MODE   = 3'd3,
    REG_FS_SAVED  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_WILL_RX = 3'd0,
    PH_WAIT_RX = 3'd1,
    PH_GOT_PKT = 3'd2,
    PH_PREP_TX = 3'd3,
    PH_WAIT_TX = 3'd4,
    PH_TX_DONE = 3'd5,
    PH_HOP     = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_RX_ON    = 2'd1,
    ACT_TX_PREP  = 2'd2,
    ACT_TX_START = 2'd3
  } radio_act_t;

  typedef enum logic [1:0] {
    FS_NONE  = 2'd0,
    FS_STOP  = 2'd1,
    FS_SAVED = 2'd2
  } fs_event_t;

  typedef enum logic [1:0] {
    MODE_AUTO  = 2'd0,
    MODE_STOP  = 2'd1,
    MODE_SAVED = 2'd2
  } fs_mode_t;

  typedef struct packed {
    logic        bound;
    logic [15:0] bind_code;
    logic [15:0] failsafe_delay_ms;
    logic [1:0]  failsafe_mode;
    logic        saved_values_present;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        pkt_ready;
    logic [7:0]  rx_byte_count;
    logic [15:0] pkt_bind;
    logic [7:0]  pkt_len_byte;
    logic [7:0]  pkt_frame_counter;
    logic [7:0]  pkt_rssi;
    logic        button_held;
  } item_t;

  typedef struct packed {
    logic [1:0]       radio_action;
    logic             fifo_flush;
    logic [HOP_W-1:0] hop_channel;
    logic             toggle_antenna;
    logic             packet_accepted;
    logic [6:0]       telem_rssi;
    logic [1:0]       failsafe_event;
    logic             searching;
    logic             save_failsafe;
    logic             led_red;
    logic             led_green;
  } result_t;

endpackage

/* hw/rtl/hrsf_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsf_regs: configuration registers
// APB-style register file holding bind state, bind code and failsafe setup.
// ----------------------------------------------------------------------------
module hrsf_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hrsf_pkg::CFG_AW-1:0]   paddr,
  input  logic [hrsf_pkg::CFG_DW-1:0]   pwdata,
  output logic [hrsf_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output hrsf_pkg::cfg_t                cfg
);

  hrsf_pkg::cfg_t   cfg_r;
  hrsf_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = hrsf_pkg::reg_idx_t'(paddr[hrsf_pkg::CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bound                <= 1'b0;
      cfg_r.bind_code            <= 16'd0;
      cfg_r.failsafe_delay_ms    <= hrsf_pkg::FS_DELAY_RST;
      cfg_r.failsafe_mode        <= hrsf_pkg::MODE_AUTO;
      cfg_r.saved_values_present <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        hrsf_pkg::REG_BOUND:     cfg_r.bound                <= pwdata[0];
        hrsf_pkg::REG_BIND_CODE: cfg_r.bind_code            <= pwdata[15:0];
        hrsf_pkg::REG_FS_DELAY:  cfg_r.failsafe_delay_ms    <= pwdata[15:0];
        hrsf_pkg::REG_FS_MODE:   cfg_r.failsafe_mode        <= pwdata[1:0];
        hrsf_pkg::REG_FS_SAVED:  cfg_r.saved_values_present <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hrsf_pkg::REG_BOUND:     prdata = {31'd0, cfg_r.bound};
      hrsf_pkg::REG_BIND_CODE: prdata = {16'd0, cfg_r.bind_code};
      hrsf_pkg::REG_FS_DELAY:  prdata = {16'd0, cfg_r.failsafe_delay_ms};
      hrsf_pkg::REG_FS_MODE:   prdata = {30'd0, cfg_r.failsafe_mode};
      hrsf_pkg::REG_FS_SAVED:  prdata = {31'd0, cfg_r.saved_values_present};
      default:                 prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/hrsf_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrsf_core: link state and tick evaluation
// Holds the receive/transmit phase, hop and slot counters, timers, failsafe
// and button state; evaluates one tick combinationally per advance.
// ----------------------------------------------------------------------------
module hrsf_core #(
  parameter int HOP_CHANNELS     = hrsf_pkg::HOP_CHANNELS_DEF,
  parameter int MAX_PACKET_BYTES = hrsf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hrsf_pkg::cfg_t    cfg,
  input  hrsf_pkg::item_t   item,
  input  logic              advance,
  output hrsf_pkg::result_t res
);

  localparam int HW = hrsf_pkg::HOP_W;
  localparam logic [HW-1:0] HOP_LAST  = HW'(HOP_CHANNELS - 1);
  localparam logic [7:0]    MAX_BYTES = 8'(MAX_PACKET_BYTES);

  // (frame counter + 1) mod channel count, one entry per counter value
  logic [HW-1:0] hop_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_tab
    assign hop_tab[g] = HW'((g + 1) % HOP_CHANNELS);
  end

  hrsf_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]    slot_r, slot_nxt;
  logic [HW-1:0] hop_r, hop_nxt;
  logic          search_r, search_nxt;
  logic [31:0]   last_pkt_r, last_pkt_nxt;
  logic [31:0]   next_pkt_r, next_pkt_nxt;
  logic [31:0]   last_hop_r, last_hop_nxt;
  logic [31:0]   tx_start_r, tx_start_nxt;
  logic [1:0]    fp_stage_r, fp_stage_nxt;
  logic          fs_act_r, fs_act_nxt;
  logic [31:0]   btn_start_r, btn_start_nxt;
  logic          btn_done_r, btn_done_nxt;
  logic [7:0]    rssi_r, rssi_nxt;
  logic          red_r, red_nxt;
  logic          green_r, green_nxt;
  logic [HW-1:0] held_hop_r, held_hop_nxt;
  logic [1:0]    held_slot_r, held_slot_nxt;

  logic          pkt_ok, rx_late, link_lost, search_due, tx_go, tx_end;
  logic [HW-1:0] hop_inc;
  logic [1:0]    slot_inc;
  logic          fs_fire, save_fire;
  logic [1:0]    action, event_code;
  logic          flush, toggle, accepted;

  assign pkt_ok = item.pkt_ready && (item.rx_byte_count > hrsf_pkg::MIN_RX_BYTES) &&
                  (item.rx_byte_count < MAX_BYTES) && (item.pkt_bind == cfg.bind_code) &&
                  (item.pkt_len_byte == hrsf_pkg::PKT_LEN_BYTE);
  assign rx_late    = item.now_ms > (next_pkt_r + hrsf_pkg::LATE_MS);
  assign link_lost  = item.now_ms > (last_pkt_r + hrsf_pkg::LOST_MS);
  assign search_due = item.now_ms > (last_hop_r + hrsf_pkg::SEARCH_HOP_MS);
  assign tx_go      = item.now_ms > tx_start_r;
  assign tx_end     = item.now_ms > (tx_start_r + hrsf_pkg::TX_LEN_MS);
  assign hop_inc    = (hop_r == HOP_LAST) ? '0 : hop_r + 1'b1;
  assign slot_inc   = slot_r + 2'd1;

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    slot_nxt      = slot_r;
    hop_nxt       = hop_r;
    search_nxt    = search_r;
    last_pkt_nxt  = last_pkt_r;
    next_pkt_nxt  = next_pkt_r;
    last_hop_nxt  = last_hop_r;
    tx_start_nxt  = tx_start_r;
    fp_stage_nxt  = fp_stage_r;
    fs_act_nxt    = fs_act_r;
    btn_start_nxt = btn_start_r;
    btn_done_nxt  = btn_done_r;
    rssi_nxt      = rssi_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    held_hop_nxt  = held_hop_r;
    held_slot_nxt = held_slot_r;
    fs_fire       = 1'b0;
    save_fire     = 1'b0;

    unique case (phase_r)
      hrsf_pkg::PH_WILL_RX: phase_nxt = hrsf_pkg::PH_WAIT_RX;
      hrsf_pkg::PH_WAIT_RX: begin
        if (pkt_ok) begin
          held_hop_nxt  = hop_tab[item.pkt_frame_counter];
          held_slot_nxt = item.pkt_frame_counter[1:0] + 2'd1;
          phase_nxt     = hrsf_pkg::PH_GOT_PKT;
        end else if (!search_r) begin
          // missed packet: advance as if it had arrived
          if (rx_late) begin
            hop_nxt      = hop_inc;
            slot_nxt     = slot_inc;
            last_hop_nxt = next_pkt_r;
            if (slot_inc == hrsf_pkg::TX_SLOT) begin
              next_pkt_nxt = next_pkt_r + hrsf_pkg::TX_SLOT_MS;
              phase_nxt    = hrsf_pkg::PH_PREP_TX;
            end else begin
              next_pkt_nxt = next_pkt_r + hrsf_pkg::SLOT_MS;
              phase_nxt    = hrsf_pkg::PH_WILL_RX;
            end
          end
          if (link_lost) begin
            search_nxt = 1'b1;
          end
        end else begin
          red_nxt = 1'b1;
          if (fp_stage_r > 2'd1) begin
            green_nxt = 1'b0;
          end
          if (search_due) begin
            hop_nxt      = hop_inc;
            slot_nxt     = 2'd0;
            last_hop_nxt = item.now_ms;
            phase_nxt    = hrsf_pkg::PH_WILL_RX;
          end
        end
      end
      hrsf_pkg::PH_GOT_PKT: begin
        last_pkt_nxt = item.now_ms;
        last_hop_nxt = item.now_ms;
        hop_nxt      = held_hop_r;
        slot_nxt     = held_slot_r;
        search_nxt   = 1'b0;
        fs_act_nxt   = 1'b0;
        red_nxt      = 1'b0;
        green_nxt    = 1'b1;
        rssi_nxt     = item.pkt_rssi;
        if (held_slot_r == hrsf_pkg::TX_SLOT) begin
          next_pkt_nxt = item.now_ms + hrsf_pkg::TX_SLOT_MS;
          phase_nxt    = hrsf_pkg::PH_PREP_TX;
        end else begin
          next_pkt_nxt = item.now_ms + hrsf_pkg::SLOT_MS;
          phase_nxt    = hrsf_pkg::PH_WILL_RX;
        end
        if (fp_stage_r == 2'd0) begin
          fp_stage_nxt = 2'd1;
        end
      end
      hrsf_pkg::PH_PREP_TX: begin
        tx_start_nxt = last_hop_r + hrsf_pkg::TX_DELAY_MS;
        last_hop_nxt = last_hop_r + hrsf_pkg::SLOT_MS;
        phase_nxt    = hrsf_pkg::PH_WAIT_TX;
      end
      hrsf_pkg::PH_WAIT_TX: begin
        if (tx_go) begin
          phase_nxt = hrsf_pkg::PH_TX_DONE;
        end
      end
      hrsf_pkg::PH_TX_DONE: begin
        if (tx_end) begin
          phase_nxt = hrsf_pkg::PH_HOP;
        end
      end
      hrsf_pkg::PH_HOP: begin
        hop_nxt   = hop_inc;
        slot_nxt  = 2'd0;
        phase_nxt = hrsf_pkg::PH_WILL_RX;
      end
      default: phase_nxt = hrsf_pkg::PH_WILL_RX;
    endcase

    if (fp_stage_nxt == 2'd1) begin
      fp_stage_nxt = 2'd2;
    end

    if ((fp_stage_nxt != 2'd0) && !fs_act_nxt &&
        ((item.now_ms - last_pkt_nxt) > {16'd0, cfg.failsafe_delay_ms})) begin
      fs_act_nxt = 1'b1;
      fs_fire    = 1'b1;
    end

    if ((fp_stage_nxt != 2'd0) && !fs_act_nxt && !btn_done_nxt) begin
      if (item.button_held && (btn_start_r == 32'd0)) begin
        btn_start_nxt = item.now_ms;
      end else if (item.button_held &&
                   ((item.now_ms - btn_start_r) > hrsf_pkg::BUTTON_HOLD_MS)) begin
        btn_done_nxt = 1'b1;
        save_fire    = 1'b1;
        red_nxt      = 1'b0;
      end
    end

    if (!item.button_held) begin
      btn_start_nxt = 32'd0;
      btn_done_nxt  = 1'b0;
    end
  end

  // tick outputs
  always_comb begin
    action   = hrsf_pkg::ACT_NONE;
    flush    = 1'b0;
    toggle   = 1'b0;
    accepted = 1'b0;
    unique case (phase_r)
      hrsf_pkg::PH_WILL_RX: action = hrsf_pkg::ACT_RX_ON;
      hrsf_pkg::PH_WAIT_RX: begin
        flush  = item.pkt_ready;
        toggle = !pkt_ok && (search_r ? search_due : rx_late);
      end
      hrsf_pkg::PH_GOT_PKT: begin
        toggle   = 1'b1;
        accepted = 1'b1;
      end
      hrsf_pkg::PH_PREP_TX: action = hrsf_pkg::ACT_TX_PREP;
      hrsf_pkg::PH_WAIT_TX: begin
        if (tx_go) begin
          action = hrsf_pkg::ACT_TX_START;
        end
      end
      default: ;
    endcase

    priority if (!fs_fire) begin
      event_code = hrsf_pkg::FS_NONE;
    end else if (cfg.failsafe_mode == hrsf_pkg::MODE_AUTO) begin
      event_code = cfg.saved_values_present ? hrsf_pkg::FS_SAVED : hrsf_pkg::FS_STOP;
    end else if (cfg.failsafe_mode == hrsf_pkg::MODE_SAVED) begin
      event_code = hrsf_pkg::FS_SAVED;
    end else begin
      event_code = hrsf_pkg::FS_STOP;
    end
  end

  always_comb begin
    if (cfg.bound) begin
      res.radio_action    = action;
      res.fifo_flush      = flush;
      res.hop_channel     = hop_nxt;
      res.toggle_antenna  = toggle;
      res.packet_accepted = accepted;
      res.telem_rssi      = rssi_nxt[6:0];
      res.failsafe_event  = event_code;
      res.searching       = search_nxt;
      res.save_failsafe   = save_fire;
      res.led_red         = red_nxt;
      res.led_green       = green_nxt;
    end else begin
      res.radio_action    = hrsf_pkg::ACT_NONE;
      res.fifo_flush      = 1'b0;
      res.hop_channel     = hop_r;
      res.toggle_antenna  = 1'b0;
      res.packet_accepted = 1'b0;
      res.telem_rssi      = rssi_r[6:0];
      res.failsafe_event  = hrsf_pkg::FS_NONE;
      res.searching       = search_r;
      res.save_failsafe   = 1'b0;
      res.led_red         = red_r;
      res.led_green       = green_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hrsf_pkg::PH_WILL_RX;
      slot_r      <= 2'd0;
      hop_r       <= '0;
      search_r    <= 1'b1;
      last_pkt_r  <= 32'd0;
      next_pkt_r  <= 32'd200;
      last_hop_r  <= 32'd0;
      tx_start_r  <= 32'd0;
      fp_stage_r  <= 2'd0;
      fs_act_r    <= 1'b0;
      btn_start_r <= 32'd0;
      btn_done_r  <= 1'b0;
      rssi_r      <= 8'd0;
      red_r       <= 1'b0;
      green_r     <= 1'b0;
      held_hop_r  <= hop_tab[0];
      held_slot_r <= 2'd1;
    end else if (advance && cfg.bound) begin
      phase_r     <= phase_nxt;
      slot_r      <= slot_nxt;
      hop_r       <= hop_nxt;
      search_r    <= search_nxt;
      last_pkt_r  <= last_pkt_nxt;
      next_pkt_r  <= next_pkt_nxt;
      last_hop_r  <= last_hop_nxt;
      tx_start_r  <= tx_start_nxt;
      fp_stage_r  <= fp_stage_nxt;
      fs_act_r    <= fs_act_nxt;
      btn_start_r <= btn_start_nxt;
      btn_done_r  <= btn_done_nxt;
      rssi_r      <= rssi_nxt;
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      held_hop_r  <= held_hop_nxt;
      held_slot_r <= held_slot_nxt;
    end
  end

endmodule

/* hw/rtl/hopping_receiver_sync_failsafe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hopping_receiver_sync_failsafe: hop receiver synchronizer with failsafe
// Each input transaction is one loop tick (time, radio packet status, button
// level); each result transaction carries the radio action, antenna switch,
// hop channel, failsafe event, save request, lamps and telemetry RSSI.
//
// Usage:
// - Input channel in_valid/in_stall/in_data, result channel
//   out_valid/out_stall/out_data. A transaction moves when valid is high and
//   stall is low. Every tick gives exactly one result.
// - A tick accepted into the input register passes the tick logic into the
//   result register and leaves from there: input register, then result
//   register. One tick is accepted per cycle while the receiver does not
//   stall.
// - When the receiver stalls, the result register holds and the input
//   register fills; in_stall then rises until the result is taken.
// - Reset (rst_n low, synchronous) clears both registers and sets the link
//   to search mode with default timers and a 1000 ms failsafe delay.
// - Write configuration through the APB port only while no tick is pending.
// ----------------------------------------------------------------------------
module hopping_receiver_sync_failsafe #(
  parameter int HOP_CHANNELS     = hrsf_pkg::HOP_CHANNELS_DEF,
  parameter int MAX_PACKET_BYTES = hrsf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  hrsf_pkg::item_t             in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output hrsf_pkg::result_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hrsf_pkg::CFG_AW-1:0] paddr,
  input  logic [hrsf_pkg::CFG_DW-1:0] pwdata,
  output logic [hrsf_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  hrsf_pkg::cfg_t    cfg;
  hrsf_pkg::item_t   in_r;
  logic              in_v_r;
  hrsf_pkg::result_t res;
  hrsf_pkg::result_t out_r;
  logic              out_v_r;
  logic              adv;

  hrsf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hrsf_core #(
    .HOP_CHANNELS     (HOP_CHANNELS),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (in_r),
    .advance (adv),
    .res     (res)
  );

  // move a tick forward when the result slot is free or being drained
  assign adv       = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && !adv;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for hopping_receiver_sync_failsafe
// Drives loop ticks with a moving millisecond clock. In the receive wait,
// most ticks carry well-formed packets, timed against the bench's own copy
// of the link state. The rest are corrupted packets and noise. Every result
// is checked field by field against a cycle-free model of the receive/transmit
// cycle, search hopping, failsafe and button save. Configuration is rewritten
// between phases, including the extremes, and each write is read back.
// ----------------------------------------------------------------------------
module tb_top;
  import hrsf_pkg::*;

  localparam int         STUCK_LIMIT = 2000;
  localparam logic [1:0] MODE_SPARE  = 2'd3;  // unused code, behaves as stop

  localparam result_t UNBOUND_RES = '{ACT_NONE, 1'b0, 6'd0, 1'b0, 1'b0, 7'd0,
                                      FS_NONE, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam result_t FIRST_RX_RES = '{ACT_RX_ON, 1'b0, 6'd0, 1'b0, 1'b0, 7'd0,
                                       FS_NONE, 1'b1, 1'b0, 1'b0, 1'b0};

  typedef struct {
    logic    bound_on;
    item_t   tick;
    logic    typed;
    result_t want;
  } row_t;

  typedef struct packed {
    logic    typed;
    result_t want;
  } hand_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  item_t               in_data;
  logic                out_valid;
  logic                out_stall;
  result_t             out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  // link model state, at its reset values
  cfg_t        cfg          = '{1'b0, 16'd0, FS_DELAY_RST, 2'd0, 1'b0};
  phase_t      link_ph      = PH_WILL_RX;
  logic [1:0]  slot         = 2'd0;
  logic [5:0]  hop          = 6'd0;
  logic        searching    = 1'b1;
  logic [31:0] last_pkt_ms  = 32'd0;
  logic [31:0] next_pkt_ms  = 32'd200;
  logic [31:0] last_hop_ms  = 32'd0;
  logic [31:0] tx_start_ms  = 32'd0;
  logic [1:0]  first_stage  = 2'd0;
  logic        fs_active    = 1'b0;
  logic [31:0] btn_start_ms = 32'd0;
  logic        btn_done     = 1'b0;
  logic [7:0]  rssi_q       = 8'd0;
  logic [7:0]  fc_latch     = 8'd0;
  logic        red          = 1'b0;
  logic        green        = 1'b0;

  result_t     awaited_results [$];
  hand_t       hand_q [$];
  row_t        rows [24];

  logic [31:0] clock_ms  = 32'd0;
  logic        btn_level = 1'b0;
  logic        in_quiet  = 1'b0;
  logic        out_quiet = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stuck_cycles = 0;
  int unsigned errors = 0;
  int unsigned ticks_taken = 0;
  int unsigned results_seen = 0;
  int unsigned pkts_taken = 0;
  int unsigned fs_fired = 0;
  int unsigned saves_seen = 0;

  hopping_receiver_sync_failsafe DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      errors++;
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    end
  endtask

  function automatic logic [5:0] hop_after(input logic [5:0] h);
    return 6'((int'(h) + 1) % HOP_CHANNELS_DEF);
  endfunction

  // One loop tick of the receiver: update the link state, return the result.
  function automatic result_t advance_link(input item_t t);
    result_t r;
    logic    got;
    r = '0;
    got = 1'b0;
    if (cfg.bound) begin
      case (link_ph)
        PH_WILL_RX: begin
          r.radio_action = ACT_RX_ON;
          link_ph = PH_WAIT_RX;
        end
        PH_WAIT_RX: begin
          if (t.pkt_ready) begin
            r.fifo_flush = 1'b1;
            if (t.rx_byte_count > MIN_RX_BYTES &&
                t.rx_byte_count < 8'(MAX_PACKET_BYTES_DEF) &&
                t.pkt_bind == cfg.bind_code && t.pkt_len_byte == PKT_LEN_BYTE) begin
              fc_latch = t.pkt_frame_counter;
              link_ph = PH_GOT_PKT;
              got = 1'b1;
            end
          end
          if (!got && !searching) begin
            // packet late: advance as if it had come
            if (t.now_ms > next_pkt_ms + LATE_MS) begin
              hop = hop_after(hop);
              slot = slot + 2'd1;
              r.toggle_antenna = 1'b1;
              last_hop_ms = next_pkt_ms;
              if (slot == TX_SLOT) begin
                next_pkt_ms = next_pkt_ms + TX_SLOT_MS;
                link_ph = PH_PREP_TX;
              end else begin
                next_pkt_ms = next_pkt_ms + SLOT_MS;
                link_ph = PH_WILL_RX;
              end
            end
            if (t.now_ms > last_pkt_ms + LOST_MS)
              searching = 1'b1;
          end else if (!got) begin
            red = 1'b1;
            if (first_stage > 2'd1)
              green = 1'b0;
            if (t.now_ms > last_hop_ms + SEARCH_HOP_MS) begin
              hop = hop_after(hop);
              slot = 2'd0;
              last_hop_ms = t.now_ms;
              r.toggle_antenna = 1'b1;
              link_ph = PH_WILL_RX;
            end
          end
        end
        PH_GOT_PKT: begin
          last_pkt_ms = t.now_ms;
          last_hop_ms = t.now_ms;
          hop = 6'((int'(fc_latch) + 1) % HOP_CHANNELS_DEF);
          slot = fc_latch[1:0] + 2'd1;
          searching = 1'b0;
          fs_active = 1'b0;
          red = 1'b0;
          green = 1'b1;
          r.toggle_antenna = 1'b1;
          r.packet_accepted = 1'b1;
          rssi_q = t.pkt_rssi;
          if (slot == TX_SLOT) begin
            next_pkt_ms = t.now_ms + TX_SLOT_MS;
            link_ph = PH_PREP_TX;
          end else begin
            next_pkt_ms = t.now_ms + SLOT_MS;
            link_ph = PH_WILL_RX;
          end
          if (first_stage == 2'd0)
            first_stage = 2'd1;
        end
        PH_PREP_TX: begin
          r.radio_action = ACT_TX_PREP;
          tx_start_ms = last_hop_ms + TX_DELAY_MS;
          last_hop_ms = last_hop_ms + SLOT_MS;
          link_ph = PH_WAIT_TX;
        end
        PH_WAIT_TX: begin
          if (t.now_ms > tx_start_ms) begin
            r.radio_action = ACT_TX_START;
            link_ph = PH_TX_DONE;
          end
        end
        PH_TX_DONE: begin
          if (t.now_ms > tx_start_ms + TX_LEN_MS)
            link_ph = PH_HOP;
        end
        PH_HOP: begin
          hop = hop_after(hop);
          slot = 2'd0;
          link_ph = PH_WILL_RX;
        end
        default: begin
          link_ph = PH_WILL_RX;
        end
      endcase

      if (first_stage == 2'd1)
        first_stage = 2'd2;

      if (first_stage >= 2'd1 && (t.now_ms - last_pkt_ms) > {16'd0, cfg.failsafe_delay_ms} &&
          !fs_active) begin
        fs_active = 1'b1;
        if (cfg.failsafe_mode == MODE_AUTO)
          r.failsafe_event = cfg.saved_values_present ? FS_SAVED : FS_STOP;
        else if (cfg.failsafe_mode == MODE_SAVED)
          r.failsafe_event = FS_SAVED;
        else
          r.failsafe_event = FS_STOP;
      end

      if (first_stage >= 2'd1 && !fs_active && !btn_done) begin
        if (t.button_held && btn_start_ms == 32'd0) begin
          btn_start_ms = t.now_ms;
        end else if (t.button_held && (t.now_ms - btn_start_ms) > BUTTON_HOLD_MS) begin
          btn_done = 1'b1;
          r.save_failsafe = 1'b1;
          red = 1'b0;
        end
      end

      if (!t.button_held) begin
        btn_start_ms = 32'd0;
        btn_done = 1'b0;
      end
    end

    r.hop_channel = hop;
    r.telem_rssi = rssi_q[6:0];
    r.searching = searching;
    r.led_red = red;
    r.led_green = green;
    return r;
  endfunction

  function automatic item_t tick_at(input logic [31:0] now, input logic rdy,
                                    input logic [7:0] cnt, input logic [15:0] bcode,
                                    input logic [7:0] len, input logic [7:0] fc,
                                    input logic [7:0] rssi, input logic btn);
    return '{now, rdy, cnt, bcode, len, fc, rssi, btn};
  endfunction

  // Random tick; well-formed packets are timed against the model's phase.
  function automatic item_t make_tick();
    item_t       t;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      clock_ms = clock_ms + $urandom_range(0, 3);
    else if (pick < 85)
      clock_ms = clock_ms + $urandom_range(4, 20);
    else if (pick < 93)
      clock_ms = clock_ms + $urandom_range(40, 60);
    else if (pick < 97)
      clock_ms = clock_ms + $urandom_range(900, 1200);
    else if (pick < 99)
      clock_ms = clock_ms + $urandom_range(1900, 2200);
    else
      clock_ms = $urandom;
    if ($urandom_range(0, 19) == 0)
      btn_level = !btn_level;

    t.now_ms = clock_ms;
    t.button_held = btn_level;
    t.pkt_ready = 1'($urandom);
    t.rx_byte_count = 8'($urandom);
    t.pkt_bind = 16'($urandom);
    t.pkt_len_byte = 8'($urandom);
    t.pkt_frame_counter = 8'($urandom);
    t.pkt_rssi = 8'($urandom);

    if (link_ph == PH_WAIT_RX) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        t.pkt_ready = 1'b1;
        t.rx_byte_count = 8'($urandom_range(8, 31));
        t.pkt_bind = cfg.bind_code;
        t.pkt_len_byte = PKT_LEN_BYTE;
      end else begin
        t.pkt_ready = 1'b0;
      end
      // break one field in a quarter of the receive-wait ticks
      if (pick >= 55 && pick < 80) begin
        case ($urandom_range(0, 3))
          0: t.rx_byte_count = 8'($urandom_range(0, 7));
          1: t.rx_byte_count = 8'($urandom_range(32, 255));
          2: t.pkt_bind = cfg.bind_code ^ 16'($urandom_range(1, 65535));
          default: t.pkt_len_byte = PKT_LEN_BYTE ^ 8'($urandom_range(1, 255));
        endcase
      end
    end
    return t;
  endfunction

  task automatic push_tick(input logic from_row, input item_t row_tick,
                           input logic typed, input result_t want);
    item_t       t;
    int unsigned gap;
    gap = in_quiet ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 39) == 0)
      in_quiet = !in_quiet;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    t = from_row ? row_tick : make_tick();
    hand_q.push_back('{typed, want});
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic run_random(input int unsigned n);
    repeat (n) push_tick(1'b0, '0, 1'b0, '0);
  endtask

  // Drop valid and let every outstanding result drain.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] kept;
    logic [31:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BOUND:     cfg.bound = val[0];
      REG_BIND_CODE: cfg.bind_code = val[15:0];
      REG_FS_DELAY:  cfg.failsafe_delay_ms = val[15:0];
      REG_FS_MODE:   cfg.failsafe_mode = val[1:0];
      default:       cfg.saved_values_present = val[0];
    endcase
    kept = (idx == REG_BIND_CODE || idx == REG_FS_DELAY) ? {16'd0, val[15:0]} :
           (idx == REG_FS_MODE) ? {30'd0, val[1:0]} : {31'd0, val[0]};
    // read back
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    check_field("register readback", rd, kept);
  endtask

  // receiver: after each result, hold stall until the drawn hold_left runs out
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    hand_t   hand;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = advance_link(in_data);
        hand = hand_q.pop_front();
        if (hand.typed)
          want = hand.want;
        awaited_results.push_back(want);
        ticks_taken++;
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        results_seen++;
        if (awaited_results.size() == 0) begin
          check_field("result with nothing pending", 32'd1, 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (want.packet_accepted) pkts_taken++;
          if (want.failsafe_event != FS_NONE) fs_fired++;
          if (want.save_failsafe) saves_seen++;
          check_field("radio_action", 32'(got.radio_action), 32'(want.radio_action));
          check_field("fifo_flush", 32'(got.fifo_flush), 32'(want.fifo_flush));
          check_field("hop_channel", 32'(got.hop_channel), 32'(want.hop_channel));
          check_field("toggle_antenna", 32'(got.toggle_antenna),
                      32'(want.toggle_antenna));
          check_field("packet_accepted", 32'(got.packet_accepted),
                      32'(want.packet_accepted));
          check_field("telem_rssi", 32'(got.telem_rssi), 32'(want.telem_rssi));
          check_field("failsafe_event", 32'(got.failsafe_event),
                      32'(want.failsafe_event));
          check_field("searching", 32'(got.searching), 32'(want.searching));
          check_field("save_failsafe", 32'(got.save_failsafe),
                      32'(want.save_failsafe));
          check_field("led_red", 32'(got.led_red), 32'(want.led_red));
          check_field("led_green", 32'(got.led_green), 32'(want.led_green));
        end
        hold_left = out_quiet ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 39) == 0)
          out_quiet = !out_quiet;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", stuck_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    cfg_write(REG_BIND_CODE, 32'h0000_A5C3);
    cfg_write(REG_FS_DELAY, 32'd1000);
    cfg_write(REG_FS_MODE, 32'(MODE_AUTO));
    cfg_write(REG_FS_SAVED, 32'd0);

    // unbound ticks change nothing; scripted link-up, telemetry slot, failsafe
    rows[0]  = '{1'b0, tick_at(32'hFFFF_FFFF, 1'b1, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
                               1'b1), 1'b1, UNBOUND_RES};
    rows[1]  = '{1'b0, tick_at(32'd0, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0),
                 1'b1, UNBOUND_RES};
    rows[2]  = '{1'b1, tick_at(32'd0, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0),
                 1'b1, FIRST_RX_RES};
    rows[3]  = '{1'b1, tick_at(32'd10, 1'b1, 8'd7, 16'hA5C3, 8'h11, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[4]  = '{1'b1, tick_at(32'd20, 1'b1, 8'd32, 16'hA5C3, 8'h11, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[5]  = '{1'b1, tick_at(32'd30, 1'b1, 8'd20, 16'hA5C2, 8'h11, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[6]  = '{1'b1, tick_at(32'd40, 1'b1, 8'd20, 16'hA5C3, 8'h10, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[7]  = '{1'b1, tick_at(32'd50, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[8]  = '{1'b1, tick_at(32'd51, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[9]  = '{1'b1, tick_at(32'd52, 1'b1, 8'd8, 16'hA5C3, 8'h11, 8'hFF, 8'd0, 1'b0),
                 1'b0, '0};
    rows[10] = '{1'b1, tick_at(32'd53, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'hFF, 1'b0),
                 1'b0, '0};
    rows[11] = '{1'b1, tick_at(32'd54, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[12] = '{1'b1, tick_at(32'd55, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[13] = '{1'b1, tick_at(32'd56, 1'b1, 8'd31, 16'hA5C3, 8'h11, 8'h2E, 8'd0, 1'b0),
                 1'b0, '0};
    rows[14] = '{1'b1, tick_at(32'd57, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'h80, 1'b0),
                 1'b0, '0};
    rows[15] = '{1'b1, tick_at(32'd57, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[16] = '{1'b1, tick_at(32'd59, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[17] = '{1'b1, tick_at(32'd60, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[18] = '{1'b1, tick_at(32'd68, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[19] = '{1'b1, tick_at(32'd68, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[20] = '{1'b1, tick_at(32'd69, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[21] = '{1'b1, tick_at(32'd100, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0),
                 1'b0, '0};
    rows[22] = '{1'b1, tick_at(32'd2000, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b1),
                 1'b0, '0};
    rows[23] = '{1'b1, tick_at(32'd2001, 1'b0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b1),
                 1'b0, '0};

    foreach (rows[i]) begin
      if (rows[i].bound_on != cfg.bound) begin
        settle();
        cfg_write(REG_BOUND, 32'(rows[i].bound_on));
      end
      push_tick(1'b1, rows[i].tick, rows[i].typed, rows[i].want);
    end
    clock_ms = 32'd2001;
    btn_level = 1'b1;

    settle();
    cfg_write(REG_BIND_CODE, 32'h0000_FFFF);
    cfg_write(REG_FS_DELAY, 32'd0);
    cfg_write(REG_FS_SAVED, 32'd1);
    run_random(300);

    settle();
    cfg_write(REG_BIND_CODE, 32'd0);
    cfg_write(REG_FS_DELAY, 32'd65535);
    cfg_write(REG_FS_MODE, 32'(MODE_SAVED));
    cfg_write(REG_FS_SAVED, 32'd0);
    run_random(300);

    settle();
    cfg_write(REG_BIND_CODE, $urandom_range(0, 65535));
    cfg_write(REG_FS_DELAY, $urandom_range(200, 3000));
    cfg_write(REG_FS_MODE, 32'(MODE_STOP));
    cfg_write(REG_FS_SAVED, 32'd1);
    run_random(300);

    settle();
    cfg_write(REG_FS_DELAY, 32'd1500);
    cfg_write(REG_FS_MODE, 32'(MODE_SPARE));
    run_random(250);

    settle();
    cfg_write(REG_BOUND, 32'd0);
    run_random(60);

    // run through the 32-bit wrap of the millisecond count
    settle();
    cfg_write(REG_BOUND, 32'd1);
    cfg_write(REG_BIND_CODE, $urandom_range(0, 65535));
    cfg_write(REG_FS_DELAY, 32'd65535);
    cfg_write(REG_FS_MODE, 32'(MODE_AUTO));
    cfg_write(REG_FS_SAVED, 32'd0);
    clock_ms = 32'hFFFF_F000;
    run_random(300);

    settle();
    cfg_write(REG_FS_DELAY, $urandom_range(5, 60));
    cfg_write(REG_FS_SAVED, 32'd1);
    run_random(140);

    settle();
    repeat (8) @(posedge clk);
    if (awaited_results.size() != 0)
      check_field("results never delivered", 32'd0, 32'(awaited_results.size()));

    $display("Sent %0d ticks, compared %0d results, %0d mismatches",
             ticks_taken, results_seen, errors);
    $display("Link events seen: %0d packets taken, %0d failsafe triggers, %0d button saves",
             pkts_taken, fs_fired, saves_seen);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
